>>> hdl/skf_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// skf_pkg
// Shared types and constants for the scalar Kalman filter: fixed-point
// format, configuration register indexes, controller states and the
// command/status bundles between controller and datapath.
// ============================================================================
package skf_pkg;

    localparam int FRAC_BITS = 16;                 // Q16.16 fraction bits
    localparam int DATA_W    = 32;                 // measurement, estimate, variances
    localparam int GAIN_W    = 16;                 // unsigned 0.16 gain
    localparam int DIV_STEPS = 16;                 // fraction bits of the gain quotient
    localparam int CNT_W     = $clog2(DIV_STEPS);
    localparam int CFG_IDX_W = 2;

    localparam logic [GAIN_W:0]   ONE_Q16  = 17'h1_0000;
    localparam logic [GAIN_W-1:0] GAIN_MAX = 16'hFFFF;

    // reset values of the variance registers
    localparam logic [DATA_W-1:0] INIT_VAR_RST = 32'd65536;
    localparam logic [DATA_W-1:0] MEAS_VAR_RST = 32'd65536;
    localparam logic [DATA_W-1:0] PROC_VAR_RST = 32'd655;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_cfg_idx CFG_INIT_VAR = 2'd0;
    localparam t_cfg_idx CFG_MEAS_VAR = 2'd1;
    localparam t_cfg_idx CFG_PROC_VAR = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV_INIT,
        ST_DIV,
        ST_MUL_P,
        ST_MUL_E,
        ST_WRITE
    } t_skf_state;

    typedef struct packed {
        logic load;      // capture measurement, form P + R
        logic div_init;  // integer quotient bit, first remainder
        logic div_step;  // one fraction bit of the gain
        logic mul_p;     // (1 - gain) * P
        logic mul_e;     // gain * (z - est)
        logic write;     // commit estimate and variance, load output
    } t_skf_cmd;

    typedef struct packed {
        logic div_last;  // current divider step is the last one
    } t_skf_status;

endpackage

>>> hdl/scalar_kalman_filter.sv
`timescale 1ns / 1ps
// ============================================================================
// scalar_kalman_filter
// One-dimensional Kalman filter on signed Q16.16 measurements.
// ============================================================================
// Usage:
//   Input channel : i_valid / i_measurement, stalled by o_stall. A transaction
//                   completes on a clock edge with i_valid high, o_stall low.
//   Output channel: o_valid / o_estimate, stalled by i_stall. One estimate
//                   per measurement, in order.
//   Config port   : i_cfg_we / i_cfg_idx / i_cfg_data, one write per edge.
//                   0 = initial variance P0 (also reloads P, clears estimate),
//                   1 = measurement variance R, 2 = process variance Q.
//                   Index 3 is ignored. Write only while the block is idle.
//   Pacing        : a new measurement is taken only after the previous one
//                   has been committed. The pace is set by the restoring
//                   divider for the gain (one quotient bit per cycle,
//                   17 bits) and the two sequential multiplies.
//   Reset         : synchronous, active low; estimate 0, P = 1.0, R = 1.0,
//                   Q = 655/65536. No output pending.
//   Stall         : a new measurement is taken while a result waits; the
//                   commit step holds until the output register is free.
// ============================================================================
module scalar_kalman_filter (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // measurement transaction
    input  logic                               i_valid,
    input  logic signed [skf_pkg::DATA_W-1:0]  i_measurement,
    output logic                               o_stall,
    // estimate transaction
    output logic                               o_valid,
    output logic signed [skf_pkg::DATA_W-1:0]  o_estimate,
    input  logic                               i_stall,
    // configuration writes
    input  logic                               i_cfg_we,
    input  skf_pkg::t_cfg_idx                  i_cfg_idx,
    input  logic        [skf_pkg::DATA_W-1:0]  i_cfg_data
);
    import skf_pkg::*;

    t_skf_cmd    w_cmd;
    t_skf_status w_status;

    // sequencer: IDLE -> DIV_INIT -> DIV x16 -> MUL_P -> MUL_E -> WRITE
    skf_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .i_status (w_status),
        .o_cmd    (w_cmd)
    );

    // arithmetic and filter state
    skf_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_status      (w_status),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_measurement (i_measurement),
        .o_estimate    (o_estimate)
    );

endmodule

>>> hdl/skf_ctrl.sv
`timescale 1ns / 1ps
// ============================================================================
// skf_ctrl
// Sequencer for one filter update: accept, divide, two multiplies, commit.
// Owns the input stall and the output valid flag.
// ============================================================================
module skf_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    output logic                 o_valid,
    input  logic                 i_stall,
    input  skf_pkg::t_skf_status i_status,
    output skf_pkg::t_skf_cmd    o_cmd
);
    import skf_pkg::*;

    t_skf_state r_state, n_state;
    logic       r_o_valid, n_o_valid;
    logic       w_out_free;

    // output slot can take a new result this cycle
    assign w_out_free = !r_o_valid || !i_stall;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:     if (i_valid) n_state = ST_DIV_INIT;
            ST_DIV_INIT: n_state = ST_DIV;
            ST_DIV:      if (i_status.div_last) n_state = ST_MUL_P;
            ST_MUL_P:    n_state = ST_MUL_E;
            ST_MUL_E:    n_state = ST_WRITE;
            ST_WRITE:    if (w_out_free) n_state = ST_IDLE;
            default:     n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd   = '0;
        o_stall = 1'b1;
        case (r_state)
            ST_IDLE: begin
                o_stall    = 1'b0;
                o_cmd.load = i_valid;
            end
            ST_DIV_INIT: o_cmd.div_init = 1'b1;
            ST_DIV:      o_cmd.div_step = 1'b1;
            ST_MUL_P:    o_cmd.mul_p    = 1'b1;
            ST_MUL_E:    o_cmd.mul_e    = 1'b1;
            ST_WRITE:    o_cmd.write    = w_out_free;
            default:     o_cmd          = '0;
        endcase
    end

    always_comb begin
        n_o_valid = r_o_valid && i_stall;
        if (o_cmd.write) n_o_valid = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_o_valid <= n_o_valid;
        end
    end

    assign o_valid = r_o_valid;

    // a waiting result is never overwritten
    a_hold_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_WRITE && r_o_valid && i_stall) |=> (r_state == ST_WRITE))
        else $error("skf_ctrl: left WRITE while result still pending");

    a_write_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.write |=> r_o_valid)
        else $error("skf_ctrl: commit did not raise output valid");

    a_div_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV && i_status.div_last) |=> (r_state == ST_MUL_P))
        else $error("skf_ctrl: divider did not hand over to multiply");

    a_cmd_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(o_cmd))
        else $error("skf_ctrl: more than one datapath command");

endmodule

>>> hdl/skf_dp.sv
`timescale 1ns / 1ps
// ============================================================================
// skf_dp
// Filter datapath: variance registers, state, restoring gain divider,
// multipliers and the commit adders, the one for the variance with saturation.
// ============================================================================
module skf_dp (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  skf_pkg::t_skf_cmd                      i_cmd,
    output skf_pkg::t_skf_status                   o_status,
    input  logic                                   i_cfg_we,
    input  skf_pkg::t_cfg_idx                      i_cfg_idx,
    input  logic        [skf_pkg::DATA_W-1:0]      i_cfg_data,
    input  logic signed [skf_pkg::DATA_W-1:0]      i_measurement,
    output logic signed [skf_pkg::DATA_W-1:0]      o_estimate
);
    import skf_pkg::*;

    // variances and state
    logic        [DATA_W-1:0]   r_meas_var;
    logic        [DATA_W-1:0]   r_proc_var;
    logic        [DATA_W-1:0]   r_p;
    logic signed [DATA_W-1:0]   r_est;

    // per-item working registers
    logic signed [DATA_W-1:0]   r_z;
    logic        [DATA_W:0]     r_den;
    logic        [DATA_W:0]     r_rem;
    logic        [GAIN_W:0]     r_quo;
    logic        [CNT_W-1:0]    r_cnt;
    logic        [GAIN_W+DATA_W:0]   r_np_prod;
    logic signed [GAIN_W+DATA_W+1:0] r_corr_prod;
    logic signed [DATA_W-1:0]   r_o_estimate;

    logic        [DATA_W:0]     w_p_ext;
    logic                       w_q_int;
    logic        [DATA_W:0]     w_rem0;
    logic        [DATA_W+1:0]   w_rem2;
    logic        [DATA_W+1:0]   w_rem_sub;
    logic                       w_ge;
    logic        [GAIN_W-1:0]   w_gain;
    logic        [GAIN_W:0]     w_one_minus;
    logic signed [GAIN_W:0]     w_gain_s;
    logic signed [DATA_W:0]     w_diff;
    logic signed [GAIN_W+DATA_W+1:0] w_corr;
    logic        [DATA_W-1:0]   w_np;
    logic        [DATA_W:0]     w_p_sum;
    logic        [DATA_W-1:0]   w_p_new;
    logic signed [DATA_W-1:0]   w_est_new;

    assign w_p_ext = {1'b0, r_p};

    // integer bit of P/(P+R): set only when R is zero
    assign w_q_int = (w_p_ext >= r_den);
    assign w_rem0  = w_p_ext - (w_q_int ? r_den : '0);

    // one restoring step per cycle
    assign w_rem2    = {r_rem, 1'b0};
    assign w_rem_sub = w_rem2 - {1'b0, r_den};
    assign w_ge      = (w_rem2 >= {1'b0, r_den});

    // zero denominator gives zero gain; quotient of exactly 1.0 saturates
    always_comb begin
        if (r_den == '0) begin
            w_gain = '0;
        end else if (r_quo[GAIN_W]) begin
            w_gain = GAIN_MAX;
        end else begin
            w_gain = r_quo[GAIN_W-1:0];
        end
    end

    assign w_one_minus = ONE_Q16 - {1'b0, w_gain};
    assign w_gain_s    = signed'({1'b0, w_gain});
    assign w_diff      = {r_z[DATA_W-1], r_z} - {r_est[DATA_W-1], r_est};

    // arithmetic shift is floor toward minus infinity
    assign w_corr    = r_corr_prod >>> FRAC_BITS;
    assign w_est_new = r_est + signed'(w_corr[DATA_W-1:0]);

    assign w_np    = r_np_prod[FRAC_BITS+DATA_W-1:FRAC_BITS];
    assign w_p_sum = {1'b0, w_np} + {1'b0, r_proc_var};
    assign w_p_new = w_p_sum[DATA_W] ? '1 : w_p_sum[DATA_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_meas_var <= MEAS_VAR_RST;
            r_proc_var <= PROC_VAR_RST;
            r_p        <= INIT_VAR_RST;
            r_est      <= '0;
        end else begin
            if (i_cmd.write) begin
                r_p   <= w_p_new;
                r_est <= w_est_new;
            end
            // initial variance is only ever needed at the moment it is written
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_INIT_VAR: begin
                        r_p   <= i_cfg_data;
                        r_est <= '0;
                    end
                    CFG_MEAS_VAR: r_meas_var <= i_cfg_data;
                    CFG_PROC_VAR: r_proc_var <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_cmd.div_init) begin
            r_cnt <= '0;
        end else if (i_cmd.div_step) begin
            r_cnt <= r_cnt + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_z   <= i_measurement;
            r_den <= w_p_ext + {1'b0, r_meas_var};
        end
        if (i_cmd.div_init) begin
            r_rem <= w_rem0;
            r_quo <= {w_q_int, {GAIN_W{1'b0}}};
        end
        if (i_cmd.div_step) begin
            r_rem <= w_ge ? w_rem_sub[DATA_W:0] : w_rem2[DATA_W:0];
            r_quo <= {r_quo[GAIN_W], r_quo[GAIN_W-2:0], w_ge};
        end
        if (i_cmd.mul_p) begin
            r_np_prod <= w_one_minus * r_p;
        end
        if (i_cmd.mul_e) begin
            r_corr_prod <= w_gain_s * w_diff;
        end
        if (i_cmd.write) begin
            r_o_estimate <= w_est_new;
        end
    end

    assign o_status.div_last = (r_cnt == CNT_W'(DIV_STEPS - 1));
    assign o_estimate        = r_o_estimate;

endmodule

>>> tb/scalar_kalman_filter_test.sv
`timescale 1ns / 1ps
// ============================================================================
// scalar_kalman_filter_test
// Self-checking bench for the 1-D Kalman filter. A scoreboard object runs a
// bit-exact fixed-point copy of the filter and queues one expected estimate
// per accepted measurement. Directed bursts cover the field extremes, the
// zero denominator, the saturated gain with R = 0, the saturated variance and
// the ignored register index. Random blocks then follow, under changing
// register settings and handshake pressure.
// ============================================================================
module scalar_kalman_filter_test;
    import skf_pkg::*;

    localparam int       CLK_HALF     = 5;
    localparam int       QUIET_LIMIT  = 4000;  // cycles with no transaction at all
    localparam int       DRAIN_CYCLES = 40;    // idle stretch at the end, longer than one filter update
    localparam int       BLOCKS       = 8;
    localparam int       BLOCK_ITEMS  = 250;
    localparam int       SHOWN_ERRORS = 10;
    localparam t_cfg_idx CFG_UNUSED   = 2'd3;  // no register behind this index

    // ------------------------------------------------------------------------
    // Scoreboard: fixed-point filter copy plus the queue of expected estimates
    // ------------------------------------------------------------------------
    class estimate_scoreboard;
        logic        [DATA_W-1:0] init_var;
        logic        [DATA_W-1:0] meas_var;
        logic        [DATA_W-1:0] proc_var;
        logic        [DATA_W-1:0] cur_var;
        logic signed [DATA_W-1:0] cur_est;
        logic signed [DATA_W-1:0] pending_estimates[$];
        int                       mismatches;

        function new();
            init_var   = INIT_VAR_RST;
            meas_var   = MEAS_VAR_RST;
            proc_var   = PROC_VAR_RST;
            cur_var    = INIT_VAR_RST;
            cur_est    = '0;
            mismatches = 0;
        endfunction

        function void write_register(t_cfg_idx idx, logic [DATA_W-1:0] data);
            case (idx)
                CFG_INIT_VAR: begin
                    // P0 write also restarts the filter
                    init_var = data;
                    cur_var  = data;
                    cur_est  = '0;
                end
                CFG_MEAS_VAR: meas_var = data;
                CFG_PROC_VAR: proc_var = data;
                default: ;
            endcase
        endfunction

        // one filter step for an accepted measurement
        function void take_measurement(logic signed [DATA_W-1:0] z);
            logic [DATA_W:0]          den;
            logic [DATA_W+15:0]       quot;
            logic [GAIN_W-1:0]        gain;
            logic [DATA_W+16:0]       shrunk;
            logic [DATA_W+1:0]        grown;
            longint                   diff;
            longint                   corr;
            den  = {1'b0, cur_var} + {1'b0, meas_var};
            gain = '0;
            if (den != 0) begin
                quot = {cur_var, 16'h0000} / den;
                gain = (quot > GAIN_MAX) ? GAIN_MAX : quot[GAIN_W-1:0];
            end
            // (1 - gain) * P, exact, then drop the fraction
            shrunk = (ONE_Q16 - gain) * cur_var;
            // gain * (z - est), floored by the arithmetic shift
            diff    = longint'(z) - longint'(cur_est);
            corr    = (longint'(gain) * diff) >>> FRAC_BITS;
            cur_est = cur_est + corr[DATA_W-1:0];
            // P + Q saturates
            grown   = {2'b00, shrunk[DATA_W+15:FRAC_BITS]} + proc_var;
            cur_var = (grown > 34'h0_FFFF_FFFF) ? 32'hFFFF_FFFF : grown[DATA_W-1:0];
            pending_estimates.push_back(cur_est);
        endfunction

        function void check_estimate(logic signed [DATA_W-1:0] got);
            logic signed [DATA_W-1:0] want;
            if (pending_estimates.size() == 0) begin
                mismatches++;
                if (mismatches <= SHOWN_ERRORS)
                    $display("%0t: estimate %h with nothing outstanding", $realtime, got);
            end else begin
                want = pending_estimates.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= SHOWN_ERRORS)
                        $display("%0t: estimate expected %h actual %h",
                                 $realtime, want, got);
                end
            end
        endfunction

        function int outstanding();
            return pending_estimates.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // DUT hookup; every input known from time zero
    // ------------------------------------------------------------------------
    logic                       i_clk         = 1'b0;
    logic                       i_rst_n       = 1'b0;
    logic                       i_valid       = 1'b0;
    logic signed [DATA_W-1:0]   i_measurement = '0;
    logic                       o_stall;
    logic                       o_valid;
    logic signed [DATA_W-1:0]   o_estimate;
    logic                       i_stall       = 1'b0;
    logic                       i_cfg_we      = 1'b0;
    t_cfg_idx                   i_cfg_idx     = CFG_INIT_VAR;
    logic        [DATA_W-1:0]   i_cfg_data    = '0;

    estimate_scoreboard         sb;
    int                         send_idle_pct = 0;
    int                         stall_pct     = 0;
    int                         quiet_cycles  = 0;
    logic        [DATA_W-1:0]   burst[$];

    scalar_kalman_filter dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .i_measurement (i_measurement),
        .o_stall       (o_stall),
        .o_valid       (o_valid),
        .o_estimate    (o_estimate),
        .i_stall       (i_stall),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // Output side: check each accepted estimate, then pick next cycle's stall.
    // Values read right after the edge are the ones the edge sampled.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall)
            sb.check_estimate(o_estimate);
        i_stall <= ($urandom_range(99) < stall_pct);
    end

    // Watchdog: a stretch that reaches QUIET_LIMIT with no transaction on either channel is a hang
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("[scalar_kalman_filter] ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Drivers; each task is entered and left right after a rising edge
    // ------------------------------------------------------------------------
    // one write at a time; the enable is low again before the next one, so it is driven once per step
    task automatic cfg_write(input t_cfg_idx idx, input logic [DATA_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        sb.write_register(idx, data);
        i_cfg_we   <= 1'b0;
        @(posedge i_clk);
    endtask

    // R and Q first, P0 last so the restart sees the final setting
    task automatic apply_config(input logic [DATA_W-1:0] p0, input logic [DATA_W-1:0] r,
                                input logic [DATA_W-1:0] q);
        cfg_write(CFG_MEAS_VAR, r);
        cfg_write(CFG_PROC_VAR, q);
        cfg_write(CFG_INIT_VAR, p0);
    endtask

    // Holds valid across back-to-back transactions; the only low stretch is
    // a sender gap, so valid sees one assignment per time step.
    task automatic send_measurement(input logic [DATA_W-1:0] z);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_measurement <= z;
        do @(posedge i_clk); while (o_stall);
        sb.take_measurement(z);
    endtask

    task automatic send_burst();
        foreach (burst[k])
            send_measurement(burst[k]);
        i_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (sb.outstanding() != 0)
            @(posedge i_clk);
    endtask

    task automatic set_pressure(input int mode);
        case (mode)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 84; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 84; end
            default: begin send_idle_pct = 28; stall_pct = 28; end
        endcase
    endtask

    // Mostly small variances, with the extremes and full-range values mixed in
    function automatic logic [DATA_W-1:0] random_variance();
        case ($urandom_range(7))
            0:       return '0;
            1:       return 32'hFFFF_FFFF;
            2:       return $urandom;
            3:       return $urandom_range(0, 1000);
            4:       return 32'h0001_0000;
            default: return $urandom_range(1, 32'h0004_0000);
        endcase
    endfunction

    // Sensor-like samples around a center, with noise and extremes mixed in
    function automatic logic [DATA_W-1:0] random_measurement(input logic [DATA_W-1:0] center);
        int pick;
        pick = $urandom_range(99);
        if (pick < 55)
            return center + $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
        else if (pick < 80)
            return $urandom;
        else if (pick < 90)
            case ($urandom_range(3))
                0:       return 32'h7FFF_FFFF;
                1:       return 32'h8000_0000;
                2:       return 32'hFFFF_FFFF;
                default: return '0;
            endcase
        else
            return $urandom_range(0, 32'h0001_FFFF) - 32'h0001_0000;
    endfunction

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial begin
        logic [DATA_W-1:0] center;
        sb = new();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings, field extremes back to back
        set_pressure(0);
        burst = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF,
                  32'h0000_0000, 32'h0001_0000};
        send_burst();
        wait_drained();

        // P + R == 0: gain is zero, estimate must stay put
        apply_config('0, '0, '0);
        burst = '{32'h7FFF_FFFF, 32'h8000_0000};
        send_burst();
        wait_drained();

        // R == 0 with P > 0: gain clamps just below one
        apply_config(32'h0001_0000, '0, 32'h0001_0000);
        burst = '{32'h1234_5678, 32'h8000_0000, 32'h7FFF_FFFF};
        send_burst();
        wait_drained();

        // everything at full scale: P + Q saturates
        apply_config(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        burst = '{32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_0000};
        send_burst();
        wait_drained();

        // unused index must not disturb the filter
        apply_config(INIT_VAR_RST, MEAS_VAR_RST, PROC_VAR_RST);
        cfg_write(CFG_UNUSED, 32'hFFFF_FFFF);
        burst = '{32'h0005_0000, 32'hFFFB_0000};
        send_burst();
        wait_drained();

        // random blocks; pressure rotates, settings change only when drained
        for (int blk = 0; blk < BLOCKS; blk++) begin
            set_pressure(blk % 4);
            if ($urandom_range(3) == 0)
                cfg_write(CFG_UNUSED, $urandom);
            apply_config(random_variance(), random_variance(), random_variance());
            center = $urandom;
            for (int n = 0; n < BLOCK_ITEMS; n++) begin
                // the tracked signal drifts now and then
                if ($urandom_range(49) == 0)
                    center = $urandom;
                send_measurement(random_measurement(center));
            end
            i_valid <= 1'b0;
            wait_drained();
        end

        set_pressure(0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.outstanding() == 0)
            $display("[scalar_kalman_filter] OK");
        else
            $display("[scalar_kalman_filter] ERROR");
        $finish;
    end

endmodule

>>> files.f
hdl/skf_pkg.sv
hdl/skf_ctrl.sv
hdl/skf_dp.sv
hdl/scalar_kalman_filter.sv
tb/scalar_kalman_filter_test.sv
